[hdl/m4cm_pkg.sv]
// Shared constants, types and binary32 rounding helpers for the matrix column multiplier.
package m4cm_pkg;

   localparam int unsigned FP_W       = 32;
   localparam int unsigned ROWS       = 4;
   localparam int unsigned COL_W      = 2;
   localparam int unsigned PIPE_DEPTH = 8;   // stages between input register and output register

   localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MUL  = 1'b1;

   // operand class flags carried from the unpack stage to the round stage
   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
   } class_type;

   function automatic logic is_nan(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
   endfunction

   // leading zero count of a 48-bit word, 48 when the word is zero
   function automatic logic [5:0] lzc48(input logic [47:0] w);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (w[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

   // Value is w * 2^(t-173) plus a sticky bit below w. Normalizes (or denormalizes),
   // rounds to nearest even and packs as binary32.
   function automatic logic [31:0] norm_round(input logic sign, input logic signed [10:0] t,
                                              input logic [47:0] w, input logic st);
      logic [5:0]         lz;
      logic [6:0]         rsh;
      logic [111:0]       wide;
      logic [47:0]        x;
      logic               lost;
      logic signed [10:0] e;
      logic [23:0]        m;
      logic               g;
      logic               s;
      logic               inc;
      logic [24:0]        m25;
      logic [23:0]        mr;
      logic [7:0]         field;
      logic [31:0]        y;
      lz   = lzc48(w);
      lost = 1'b0;
      wide = '0;
      if (t < 11'sd0) begin
         // below the subnormal range: shift right, collect lost bits
         rsh  = (t < -11'sd63) ? 7'd63 : 7'(-t);
         wide = {w, 64'd0} >> rsh;
         x    = wide[111:64];
         lost = |wide[63:0];
         e    = 11'sd1;
      end else if (t >= $signed({5'd0, lz})) begin
         x = w << lz;
         e = t + 11'sd1 - $signed({5'd0, lz});
      end else begin
         // exponent floor reached: partial shift, subnormal result
         x = w << t[5:0];
         e = 11'sd1;
      end
      m   = x[47:24];
      g   = x[23];
      s   = (|x[22:0]) | lost | st;
      inc = g & (s | m[0]);
      m25 = {1'b0, m} + {24'd0, inc};
      if (m25[24]) begin
         mr = m25[24:1];
         e  = e + 11'sd1;
      end else begin
         mr = m25[23:0];
      end
      field = mr[23] ? e[7:0] : 8'd0;
      if (e >= 11'sd255) y = {sign, 8'hFF, 23'd0};
      else y = {sign, field, mr[22:0]};
      return y;
   endfunction

endpackage

[hdl/m4cm_req_if.sv]
// Input channel: valid/ready handshake with an op code, column index and one column.
interface m4cm_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [1:0]  in_column;
   logic [31:0] elem_0;
   logic [31:0] elem_1;
   logic [31:0] elem_2;
   logic [31:0] elem_3;

   modport source (output valid, op, in_column, elem_0, elem_1, elem_2, elem_3, input ready);
   modport sink   (input valid, op, in_column, elem_0, elem_1, elem_2, elem_3, output ready);
endinterface

[hdl/m4cm_rsp_if.sv]
// Result channel: valid/ready handshake with the result column and its index.
interface m4cm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_column;
   logic [31:0] res_0;
   logic [31:0] res_1;
   logic [31:0] res_2;
   logic [31:0] res_3;

   modport source (output valid, out_column, res_0, res_1, res_2, res_3, input ready);
   modport sink   (input valid, out_column, res_0, res_1, res_2, res_3, output ready);
endinterface

[hdl/matrix4_column_multiply.sv]
// Top level: 4x4 binary32 left matrix store and pipelined matrix-times-column datapath.
//
//  channel  dir  handshake            payload
//  req_if   in   valid/ready          op, in_column, elem_0..elem_3
//  rsp_if   out  valid/ready          out_column, res_0..res_3
//
// One item per cycle unless a stalled result holds the pipeline. A multiply item passes through:
// input register, 2-stage multipliers, three chained 2-stage adders, output register.
// A load item writes its column when it leaves the input register and gives no result.
// Reset clears all valid bits and sets the matrix to identity.
// A stalled result freezes the whole pipeline; ready is low only while it waits.
module matrix4_column_multiply (
   input  logic          clock,
   input  logic          reset,
   m4cm_req_if.sink      req_if,
   m4cm_rsp_if.source    rsp_if
);
   localparam int unsigned DEPTH = m4cm_pkg::PIPE_DEPTH;

   logic        advance;
   logic        load_write;

   logic        a_valid_ff, a_valid_in;
   logic        a_op_ff;
   logic [1:0]  a_col_ff;
   logic [31:0] a_elem_ff [4];

   logic [31:0] mat_ff [16];

   logic        mv_ff   [DEPTH];
   logic [1:0]  mcol_ff [DEPTH];

   logic [31:0] prod  [4][4];
   logic [31:0] acc0  [4];
   logic [31:0] sum1  [4];
   logic [31:0] sum2  [4];
   logic [31:0] sum3  [4];
   logic [31:0] p2_ff [4][2];
   logic [31:0] p3_ff [4][4];

   logic        rsp_valid_ff;
   logic [1:0]  rsp_col_ff;
   logic [31:0] rsp_res_ff [4];

   // whole pipeline moves unless a finished result is stuck
   assign advance    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign a_valid_in = req_if.valid;
   assign load_write = advance && a_valid_ff && (a_op_ff == m4cm_pkg::OP_LOAD);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_op_ff      <= req_if.op;
         a_col_ff     <= req_if.in_column;
         a_elem_ff[0] <= req_if.elem_0;
         a_elem_ff[1] <= req_if.elem_1;
         a_elem_ff[2] <= req_if.elem_2;
         a_elem_ff[3] <= req_if.elem_3;
      end
   end

   // left matrix, column major; loads land as they leave the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) begin
            mat_ff[k] <= (k % 5 == 0) ? m4cm_pkg::ONE_BITS : 32'd0;
         end
      end else if (load_write) begin
         for (int r = 0; r < 4; r++) begin
            mat_ff[{a_col_ff, 2'(r)}] <= a_elem_ff[r];
         end
      end
   end

   // multiply item tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) mv_ff[s] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mv_ff[0] <= a_valid_ff && (a_op_ff == m4cm_pkg::OP_MUL);
         for (int s = 1; s < DEPTH; s++) mv_ff[s] <= mv_ff[s-1];
         rsp_valid_ff <= mv_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mcol_ff[0] <= a_col_ff;
         for (int s = 1; s < DEPTH; s++) mcol_ff[s] <= mcol_ff[s-1];
         rsp_col_ff <= mcol_ff[DEPTH-1];
      end
   end

   // sixteen products, then a chained sum per row
   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar i = 0; i < 4; i++) begin : g_term
         m4cm_fmul u_mul (
            .clock (clock),
            .en    (advance),
            .a     (mat_ff[i*4 + r]),
            .b     (a_elem_ff[i]),
            .y     (prod[r][i])
         );
      end

      // sum starts at +0.0, so a negative zero first product becomes +0.0
      assign acc0[r] = (prod[r][0] == m4cm_pkg::NEG_ZERO) ? 32'd0 : prod[r][0];

      m4cm_fadd u_add1 (.clock(clock), .en(advance), .a(acc0[r]), .b(prod[r][1]), .y(sum1[r]));
      m4cm_fadd u_add2 (.clock(clock), .en(advance), .a(sum1[r]), .b(p2_ff[r][1]), .y(sum2[r]));
      m4cm_fadd u_add3 (.clock(clock), .en(advance), .a(sum2[r]), .b(p3_ff[r][3]), .y(sum3[r]));
   end

   // hold later products until their add comes up
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            p2_ff[r][0] <= prod[r][2];
            p2_ff[r][1] <= p2_ff[r][0];
            p3_ff[r][0] <= prod[r][3];
            for (int s = 1; s < 4; s++) p3_ff[r][s] <= p3_ff[r][s-1];
         end
      end
   end

   // output register with NaN made canonical
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            rsp_res_ff[r] <= m4cm_pkg::is_nan(sum3[r]) ? m4cm_pkg::QNAN_BITS : sum3[r];
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_column = rsp_col_ff;
   assign rsp_if.res_0      = rsp_res_ff[0];
   assign rsp_if.res_1      = rsp_res_ff[1];
   assign rsp_if.res_2      = rsp_res_ff[2];
   assign rsp_if.res_3      = rsp_res_ff[3];

   // a stuck result still stalls intake in the following cycle unless ready has risen
   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> (rsp_valid_ff && !req_if.ready) || rsp_if.ready)
      else $error("intake not stalled behind a waiting result");

   // a load leaving the input register lands in the matrix
   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      load_write |=> (mat_ff[{$past(a_col_ff), 2'd0}] == $past(a_elem_ff[0]))
                  && (mat_ff[{$past(a_col_ff), 2'd3}] == $past(a_elem_ff[3])))
      else $error("matrix column not written by load");

   // right after reset the matrix is identity
   a_reset_identity: assert property (@(posedge clock)
      $past(reset) && !reset |-> (mat_ff[0] == m4cm_pkg::ONE_BITS)
                               && (mat_ff[15] == m4cm_pkg::ONE_BITS) && (mat_ff[1] == 32'd0))
      else $error("matrix not identity after reset");

   // a load never turns into a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (advance && a_valid_ff && (a_op_ff == m4cm_pkg::OP_LOAD)) |=> !mv_ff[0])
      else $error("load item entered the result pipeline");
endmodule

[hdl/m4cm_fmul.sv]
// Two-stage binary32 multiplier: unpack and mantissa product, then normalize and round.
module m4cm_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   logic [7:0]  ea, eb;
   logic [7:0]  ea_adj, eb_adj;
   logic [23:0] ma, mb;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

   m4cm_pkg::class_type cls_in, cls_ff;
   logic                sign_in, sign_ff;
   logic signed [10:0]  t_in, t_ff;
   logic [47:0]         prod_in, prod_ff;
   logic [31:0]         y_in, y_ff;

   // unpack and classify
   always_comb begin
      ea     = a[30:23];
      eb     = b[30:23];
      nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (ea == 8'd0) && (a[22:0] == 23'd0);
      zero_b = (eb == 8'd0) && (b[22:0] == 23'd0);
      ma     = {ea != 8'd0, a[22:0]};
      mb     = {eb != 8'd0, b[22:0]};
      ea_adj = (ea == 8'd0) ? 8'd1 : ea;
      eb_adj = (eb == 8'd0) ? 8'd1 : eb;
      cls_in.nan  = nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
      cls_in.inf  = inf_a | inf_b;
      cls_in.zero = zero_a | zero_b;
      sign_in = a[31] ^ b[31];
      t_in    = $signed({3'd0, ea_adj}) + $signed({3'd0, eb_adj}) - 11'sd127;
      prod_in = {24'd0, ma} * {24'd0, mb};
   end

   // special cases first, otherwise normalize and round the product
   always_comb begin
      if (cls_ff.nan) y_in = m4cm_pkg::QNAN_BITS;
      else if (cls_ff.inf) y_in = {sign_ff, 8'hFF, 23'd0};
      else if (cls_ff.zero) y_in = {sign_ff, 31'd0};
      else y_in = m4cm_pkg::norm_round(sign_ff, t_ff, prod_ff, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cls_ff  <= cls_in;
         sign_ff <= sign_in;
         t_ff    <= t_in;
         prod_ff <= prod_in;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;
endmodule

[hdl/m4cm_fadd.sv]
// Two-stage binary32 adder: swap, align and add, then normalize and round.
module m4cm_fadd (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   logic [31:0] big, sml;
   logic [7:0]  e_big, e_sml;
   logic [7:0]  d;
   logic [5:0]  dc;
   logic [47:0] big_w, sml_w;
   logic [95:0] aligned;
   logic [48:0] sum;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

   m4cm_pkg::class_type cls_in, cls_ff;
   logic                sign_in, sign_ff;
   logic                inf_sign_in, inf_sign_ff;
   logic                zero_sign_in, zero_sign_ff;
   logic signed [10:0]  t_in, t_ff;
   logic [47:0]         w_in, w_ff;
   logic                st_in, st_ff;
   logic [31:0]         y_in, y_ff;

   // classify, order by magnitude, align the smaller operand and add
   always_comb begin
      nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      cls_in.nan   = nan_a | nan_b | (inf_a & inf_b & (a[31] ^ b[31]));
      cls_in.inf   = inf_a | inf_b;
      cls_in.zero  = zero_a & zero_b;
      inf_sign_in  = inf_a ? a[31] : b[31];
      zero_sign_in = a[31] & b[31];
      if (b[30:0] > a[30:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d       = e_big - e_sml;
      dc      = (d > 8'd50) ? 6'd50 : d[5:0];
      big_w   = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
      sml_w   = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
      aligned = {sml_w, 48'd0} >> dc;
      if (big[31] ^ sml[31]) sum = {big_w, 1'b0} - {aligned[95:48], |aligned[47:0]};
      else sum = {big_w, 1'b0} + {aligned[95:48], |aligned[47:0]};
      sign_in = (sum == 49'd0) ? 1'b0 : big[31];
      t_in    = $signed({3'd0, e_big});
      w_in    = sum[48:1];
      st_in   = sum[0];
   end

   // special cases first, otherwise normalize and round the sum
   always_comb begin
      if (cls_ff.nan) y_in = m4cm_pkg::QNAN_BITS;
      else if (cls_ff.inf) y_in = {inf_sign_ff, 8'hFF, 23'd0};
      else if (cls_ff.zero) y_in = {zero_sign_ff, 31'd0};
      else y_in = m4cm_pkg::norm_round(sign_ff, t_ff, w_ff, st_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cls_ff       <= cls_in;
         sign_ff      <= sign_in;
         inf_sign_ff  <= inf_sign_in;
         zero_sign_ff <= zero_sign_in;
         t_ff         <= t_in;
         w_ff         <= w_in;
         st_ff        <= st_in;
         y_ff         <= y_in;
      end
   end

   assign y = y_ff;
endmodule

[sim/tb_matrix4_column_multiply.sv]
// Testbench for matrix4_column_multiply: directed and random columns against a predictor.
`timescale 1ns / 100ps

module tb_matrix4_column_multiply;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic [1:0]        column;
      logic [3:0][31:0]  rows;
   } column_item_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   hold_left;
   bit   steady_mode;

   m4cm_req_if req_if();
   m4cm_rsp_if rsp_if();

   matrix4_column_multiply u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predictor state: left matrix, column major, and results still owed
   logic [31:0]     left_cols [16];
   column_item_type owed_columns [$];

   // binary32 bits to exact binary64 bits
   function automatic logic [63:0] widen(input logic [31:0] f);
      logic [23:0] m;
      int          ex;
      m = {1'b0, f[22:0]};
      if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
      if (f[30:0] == 31'd0) return {f[31], 63'd0};
      if (f[30:23] == 8'd0) begin
         ex = -126;
         while (!m[23]) begin
            m  = m << 1;
            ex = ex - 1;
         end
      end else begin
         ex = int'(f[30:23]) - 127;
      end
      return {f[31], 11'(ex + 1023), m[22:0], 29'd0};
   endfunction

   // binary64 bits to binary32, round to nearest even, subnormals kept
   function automatic logic [31:0] narrow(input logic [63:0] d);
      logic [52:0]  sig;
      logic [116:0] wide;
      logic [31:0]  y;
      int           biased;
      int           sh;
      sig = {1'b1, d[51:0]};
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? m4cm_pkg::QNAN_BITS : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      biased = int'(d[62:52]) - 1023 + 127;
      if (biased >= 255) return {d[63], 8'hFF, 23'd0};
      if (biased >= 1) begin
         y = {d[63], 8'(biased), sig[51:29]};
         if (sig[28] && ((|sig[27:0]) || sig[29])) y = y + 32'd1;
         return y;
      end
      // subnormal: integer count of 2^-149 units
      sh   = 30 - biased;
      if (sh > 64) sh = 64;
      wide = {sig, 64'd0} >> sh;
      y    = {d[63], 31'(wide[116:64])};
      if (wide[63] && ((|wide[62:0]) || wide[64])) y = y + 32'd1;
      return y;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      return narrow($realtobits($bitstoreal(widen(a)) + $bitstoreal(widen(b))));
   endfunction

   // one result row: sum from +0.0, products in index order
   function automatic logic [31:0] row_product(input int row, input logic [3:0][31:0] rhs);
      logic [31:0] acc;
      acc = 32'd0;
      for (int i = 0; i < 4; i++) acc = fp_add(acc, fp_mul(left_cols[i*4 + row], rhs[i]));
      if (m4cm_pkg::is_nan(acc)) acc = m4cm_pkg::QNAN_BITS;
      return acc;
   endfunction

   // apply one accepted item to the predictor
   task automatic predict_item(input logic op, input column_item_type item);
      column_item_type res;
      if (op == m4cm_pkg::OP_LOAD) begin
         for (int r = 0; r < 4; r++) left_cols[item.column*4 + r] = item.rows[r];
      end else begin
         res.column = item.column;
         for (int r = 0; r < 4; r++) res.rows[r] = row_product(r, item.rows);
         owed_columns.push_back(res);
      end
   endtask

   function automatic int gap_len();
      int pick;
      if (steady_mode) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one item, hold it until taken, then maybe idle
   task automatic send_item(input logic op, input logic [1:0] col,
                            input logic [31:0] e0, input logic [31:0] e1,
                            input logic [31:0] e2, input logic [31:0] e3);
      column_item_type item;
      int              gap;
      item.column = col;
      item.rows   = {e3, e2, e1, e0};
      req_if.valid     <= 1'b1;
      req_if.op        <= op;
      req_if.in_column <= col;
      req_if.elem_0    <= e0;
      req_if.elem_1    <= e1;
      req_if.elem_2    <= e2;
      req_if.elem_3    <= e3;
      do @(posedge clock); while (!req_if.ready);
      predict_item(op, item);
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_float();
      logic [31:0] pool [10];
      pool = '{32'h0000_0000, m4cm_pkg::NEG_ZERO, m4cm_pkg::ONE_BITS, 32'hBF80_0000,
               32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h807F_FFFF,
               32'h7FA0_0001};
      case ($urandom_range(0, 9))
         0: begin
            return pool[$urandom_range(0, 9)];
         end
         1, 2: begin
            return $urandom;
         end
         3: begin
            // near the subnormal boundary
            return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
         end
         default: begin
            return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
         end
      endcase
   endfunction

   task automatic send_random(input logic op);
      send_item(op, 2'($urandom), rand_float(), rand_float(), rand_float(), rand_float());
   endtask

   task automatic wait_drained();
      while (owed_columns.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // identity after reset, then every column loaded with extremes
   task automatic test_identity_and_loads();
      send_item(m4cm_pkg::OP_MUL, 2'd0, m4cm_pkg::ONE_BITS, 32'h4000_0000, 32'h4040_0000,
                32'h4080_0000);
      send_item(m4cm_pkg::OP_MUL, 2'd3, 32'hFFFF_FFFF, 32'h0000_0001, m4cm_pkg::NEG_ZERO,
                32'h7F7F_FFFF);
      send_item(m4cm_pkg::OP_LOAD, 2'd0, 32'h7F7F_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                m4cm_pkg::NEG_ZERO);
      send_item(m4cm_pkg::OP_LOAD, 2'd1, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                m4cm_pkg::NEG_ZERO);
      send_item(m4cm_pkg::OP_LOAD, 2'd2, 32'h0000_0000, 32'h7F80_0000, 32'h807F_FFFF,
                m4cm_pkg::NEG_ZERO);
      send_item(m4cm_pkg::OP_LOAD, 2'd3, 32'h0000_0000, 32'hFF80_0000, 32'h0080_0000,
                m4cm_pkg::NEG_ZERO);
      // overflow, inf - inf, subnormal sums, all negative-zero products
      send_item(m4cm_pkg::OP_MUL, 2'd1, 32'h4000_0000, 32'h3F80_0000, 32'h3F80_0000,
                m4cm_pkg::ONE_BITS);
      send_item(m4cm_pkg::OP_MUL, 2'd2, m4cm_pkg::ONE_BITS, m4cm_pkg::ONE_BITS,
                m4cm_pkg::ONE_BITS, m4cm_pkg::ONE_BITS);
      send_item(m4cm_pkg::OP_MUL, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3F00_0000,
                32'h3F00_0000);
      send_item(m4cm_pkg::OP_MUL, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h3F00_0000,
                32'h3F00_0000);
      send_item(m4cm_pkg::OP_LOAD, 2'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0000_0000);
      send_item(m4cm_pkg::OP_MUL, 2'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                32'h0000_0000);
      send_item(m4cm_pkg::OP_MUL, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'hBF80_0000,
                32'h8000_0001);
      send_item(m4cm_pkg::OP_LOAD, 2'd0, 32'hBF80_0000, 32'h8000_0000, 32'h7FC1_2345,
                32'h3F80_0000);
      send_item(m4cm_pkg::OP_MUL, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0000_0000);
      send_item(m4cm_pkg::OP_MUL, 2'd3, 32'h7FFF_FFFF, m4cm_pkg::ONE_BITS, 32'h0000_0000,
                32'h0000_0000);
      // restore identity for what follows
      send_item(m4cm_pkg::OP_LOAD, 2'd0, m4cm_pkg::ONE_BITS, 32'd0, 32'd0, 32'd0);
      send_item(m4cm_pkg::OP_LOAD, 2'd1, 32'd0, m4cm_pkg::ONE_BITS, 32'd0, 32'd0);
      send_item(m4cm_pkg::OP_LOAD, 2'd2, 32'd0, 32'd0, m4cm_pkg::ONE_BITS, 32'd0);
      send_item(m4cm_pkg::OP_LOAD, 2'd3, 32'd0, 32'd0, 32'd0, m4cm_pkg::ONE_BITS);
      send_item(m4cm_pkg::OP_MUL, 2'd2, 32'h0000_0001, 32'h8000_0001, 32'h7F80_0000,
                32'h3F80_0001);
   endtask

   // receiver holds off long while items keep coming; then a full drain
   task automatic test_backpressure();
      steady_mode = 1'b1;
      hold_left   = 300;
      for (int i = 0; i < 40; i++)
         send_random(($urandom_range(0, 4) == 0) ? m4cm_pkg::OP_LOAD : m4cm_pkg::OP_MUL);
      steady_mode = 1'b0;
      req_if.valid <= 1'b0;
      wait_drained();
   endtask

   // load a fresh matrix, then a run of multiplies with noise loads mixed in
   task automatic test_random_streams();
      int n;
      n = 0;
      while (n < 680) begin
         steady_mode = ($urandom_range(0, 5) == 0);
         for (int c = 0; c < 4; c++) begin
            send_random(m4cm_pkg::OP_LOAD);
            n++;
         end
         repeat ($urandom_range(4, 20)) begin
            send_random(($urandom_range(0, 9) == 0) ? m4cm_pkg::OP_LOAD : m4cm_pkg::OP_MUL);
            n++;
         end
         if ($urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            wait_drained();
         end
      end
      steady_mode = 1'b0;
   endtask

   // clock and run limit
   initial begin
      clock       = 1'b0;
      cycle_count = 0;
      forever begin
         #1 clock = ~clock;
         if (clock) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
               $display("timeout after %0d cycles", cycle_count);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   // receiver: long hold when asked, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (steady_mode) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) < 75) ||
                         (($urandom_range(0, 99) < 3) ? 1'b0 : rsp_if.ready);
      end
   end

   // result checker
   always @(posedge clock) begin
      column_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (owed_columns.size() == 0) begin
            report_mismatch("unexpected result column", 32'(rsp_if.out_column), 32'd0);
         end else begin
            want = owed_columns.pop_front();
            if (rsp_if.out_column !== want.column)
               report_mismatch("out_column", 32'(rsp_if.out_column), 32'(want.column));
            if (rsp_if.res_0 !== want.rows[0]) report_mismatch("res_0", rsp_if.res_0, want.rows[0]);
            if (rsp_if.res_1 !== want.rows[1]) report_mismatch("res_1", rsp_if.res_1, want.rows[1]);
            if (rsp_if.res_2 !== want.rows[2]) report_mismatch("res_2", rsp_if.res_2, want.rows[2]);
            if (rsp_if.res_3 !== want.rows[3]) report_mismatch("res_3", rsp_if.res_3, want.rows[3]);
         end
      end
   end

   // test sequence
   initial begin
      reset            = 1'b1;
      error_count      = 0;
      hold_left        = 0;
      steady_mode      = 1'b0;
      req_if.valid     = 1'b0;
      req_if.op        = m4cm_pkg::OP_LOAD;
      req_if.in_column = 2'd0;
      req_if.elem_0    = 32'd0;
      req_if.elem_1    = 32'd0;
      req_if.elem_2    = 32'd0;
      req_if.elem_3    = 32'd0;
      rsp_if.ready     = 1'b0;
      for (int k = 0; k < 16; k++) left_cols[k] = (k % 5 == 0) ? m4cm_pkg::ONE_BITS : 32'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_and_loads();
      test_backpressure();
      test_random_streams();

      req_if.valid <= 1'b0;
      while (owed_columns.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && owed_columns.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
